### src/mafhd_pkg.sv
// Shared constants, lookup tables and helpers for the MPEG audio frame header decoder.
package mafhd_pkg;

  // Status codes, first failing check wins
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_SYNC     = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_BAD_LAYER   = 3'd3;
  localparam logic [2:0] ST_BAD_BITRATE = 3'd4;
  localparam logic [2:0] ST_BAD_RATE    = 3'd5;

  // Version field codes
  localparam logic [1:0] VER_25       = 2'd0;
  localparam logic [1:0] VER_RESERVED = 2'd1;
  localparam logic [1:0] VER_2        = 2'd2;
  localparam logic [1:0] VER_1        = 2'd3;

  // Layer field codes
  localparam logic [1:0] LAY_RESERVED = 2'd0;
  localparam logic [1:0] LAY_3        = 2'd1;
  localparam logic [1:0] LAY_2        = 2'd2;
  localparam logic [1:0] LAY_1        = 2'd3;

  localparam logic [1:0] MODE_MONO    = 2'd3;
  localparam logic [3:0] BRI_BAD      = 4'd15;
  localparam logic [1:0] SRI_BAD      = 2'd3;
  localparam logic [10:0] SYNC_BITS   = 11'h7FF;

  // Bitrate table rows
  localparam logic [2:0] ROW_M1_L1  = 3'd0;
  localparam logic [2:0] ROW_M1_L2  = 3'd1;
  localparam logic [2:0] ROW_M1_L3  = 3'd2;
  localparam logic [2:0] ROW_LSF_L1 = 3'd3;
  localparam logic [2:0] ROW_LSF_L23 = 3'd4;

  localparam logic [12:0] SPF_L1   = 13'd384;
  localparam logic [12:0] SPF_FULL = 13'd1152;
  localparam logic [12:0] SPF_HALF = 13'd576;

  // MPEG 1 base rates; the lower versions are these shifted right by 1 or 2
  localparam logic [15:0] BASE_HZ0 = 16'd44100;
  localparam logic [15:0] BASE_HZ1 = 16'd48000;
  localparam logic [15:0] BASE_HZ2 = 16'd32000;

  // Reciprocal scale and floor(2^RECIP_SH / base)
  localparam int RECIP_SH = 32;
  localparam int RECIP_W  = 18;
  localparam logic [RECIP_W-1:0] RECIP0 = RECIP_W'((64'd1 << RECIP_SH) / 64'd44100);
  localparam logic [RECIP_W-1:0] RECIP1 = RECIP_W'((64'd1 << RECIP_SH) / 64'd48000);
  localparam logic [RECIP_W-1:0] RECIP2 = RECIP_W'((64'd1 << RECIP_SH) / 64'd32000);

  localparam logic [8:0] KBPS_M1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KBPS_M1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KBPS_M1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KBPS_LSF_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] KBPS_LSF_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  function automatic logic [8:0] kbps_lookup(input logic [2:0] row, input logic [3:0] bri);
    logic [8:0] k;
    unique case (row)
      ROW_M1_L1:  k = KBPS_M1_L1[bri];
      ROW_M1_L2:  k = KBPS_M1_L2[bri];
      ROW_M1_L3:  k = KBPS_M1_L3[bri];
      ROW_LSF_L1: k = KBPS_LSF_L1[bri];
      default:    k = KBPS_LSF_L23[bri];
    endcase
    return k;
  endfunction

  function automatic logic [15:0] base_hz(input logic [1:0] sel);
    logic [15:0] b;
    unique case (sel)
      2'd0:    b = BASE_HZ0;
      2'd1:    b = BASE_HZ1;
      2'd2:    b = BASE_HZ2;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [RECIP_W-1:0] base_recip(input logic [1:0] sel);
    logic [RECIP_W-1:0] r;
    unique case (sel)
      2'd0:    r = RECIP0;
      2'd1:    r = RECIP1;
      2'd2:    r = RECIP2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/mpeg_audio_frame_header_decode_unit.sv
// MPEG audio frame header decoder: five-stage pipeline from header word to frame length.
//
// Takes one 32-bit frame header per word and returns one result word per header, in
// order. A header passes the s1, s2, s3 and s4 stage registers and then the output
// register that drives out_valid; one header can enter every cycle unless backpressure
// stalls the pipeline. The depth is set by the frame length division, done as a multiply
// by a fixed reciprocal of the base sample rate (44.1, 48 or 32 kHz, the lower versions
// being exact halves and quarters of these) followed by a one-step remainder fix.
// Stages: field decode and table lookup, samples*kbps*125 product, reciprocal
// multiply, quotient back-multiply, remainder fix and output register. Each stage
// holds its own valid bit and stalls only when the stage ahead is full and blocked,
// so bubbles close up under backpressure.
module mpeg_audio_frame_header_decode_unit
  import mafhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] header_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [1:0]  channels,
  output logic [15:0] sample_rate_hz,
  output logic [8:0]  bit_rate_kbps,
  output logic        padding_bit,
  output logic [11:0] frame_bytes
);

  // Stage valid bits and per-stage load enables
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Stage 1 decode
  logic [2:0]  st_next;
  logic [1:0]  ch_next;
  logic [15:0] hz_next;
  logic [8:0]  kbps_next;
  logic [19:0] s125_next;
  logic [1:0]  sel_next;

  always_comb begin
    logic [1:0]  ver, lay, sri, shift;
    logic [3:0]  bri;
    logic [2:0]  row;
    logic [12:0] spf, spf_k;
    ver = header_word[20:19];
    lay = header_word[18:17];
    bri = header_word[15:12];
    sri = header_word[11:10];

    if (header_word[31:21] != SYNC_BITS)  st_next = ST_NO_SYNC;
    else if (ver == VER_RESERVED)         st_next = ST_BAD_VERSION;
    else if (lay == LAY_RESERVED)         st_next = ST_BAD_LAYER;
    else if (bri == BRI_BAD)              st_next = ST_BAD_BITRATE;
    else if (sri == SRI_BAD)              st_next = ST_BAD_RATE;
    else                                  st_next = ST_OK;

    ch_next = (header_word[7:6] == MODE_MONO) ? 2'd1 : 2'd2;

    // bitrate table row
    if (ver == VER_1) begin
      case (lay)
        LAY_1:   row = ROW_M1_L1;
        LAY_2:   row = ROW_M1_L2;
        default: row = ROW_M1_L3;
      endcase
    end else if (lay == LAY_1) begin
      row = ROW_LSF_L1;
    end else begin
      row = ROW_LSF_L23;
    end

    // rate shift: MPEG 1 none, MPEG 2 one, MPEG 2.5 two
    case (ver)
      VER_1:   shift = 2'd0;
      VER_2:   shift = 2'd1;
      default: shift = 2'd2;
    endcase

    if (lay == LAY_1)                      spf = SPF_L1;
    else if (lay == LAY_2 || ver == VER_1) spf = SPF_FULL;
    else                                   spf = SPF_HALF;

    // samples scaled up in place of dividing the rate down
    spf_k     = spf << shift;
    s125_next = 20'(spf_k) * 20'd125;
    sel_next  = sri;

    if (st_next == ST_OK) begin
      kbps_next = kbps_lookup(row, bri);
      hz_next   = base_hz(sri) >> shift;
    end else begin
      kbps_next = '0;
      hz_next   = '0;
    end
  end

  // Stage registers
  logic [2:0]  s1_st, s2_st, s3_st, s4_st;
  logic [1:0]  s1_ch, s2_ch, s3_ch, s4_ch;
  logic [15:0] s1_hz, s2_hz, s3_hz, s4_hz;
  logic [8:0]  s1_kbps, s2_kbps, s3_kbps, s4_kbps;
  logic        s1_pad, s2_pad, s3_pad, s4_pad;
  logic [1:0]  s1_sel, s2_sel, s3_sel, s4_sel;
  logic [19:0] s1_s125;
  logic [26:0] s2_n, s3_n, s4_n;
  logic [11:0] s3_q, s4_q;
  logic [27:0] s4_qb;

  // Arithmetic between stages
  logic [28:0] prod2;
  logic [44:0] prod3;
  logic [27:0] prod4;
  logic [27:0] rem5;
  logic [15:0] base5;
  logic [11:0] bytes5;

  assign prod2  = 29'(s1_s125) * 29'(s1_kbps);
  assign prod3  = 45'(s2_n) * 45'(base_recip(s2_sel));
  assign prod4  = 28'(s3_q) * 28'(base_hz(s3_sel));
  assign base5  = base_hz(s4_sel);
  assign rem5   = 28'(s4_n) - s4_qb;
  assign bytes5 = s4_q + 12'(rem5 >= 28'(base5)) + 12'(s4_pad);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1        <= in_valid;
      if (rdy2) v2        <= v1;
      if (rdy3) v3        <= v2;
      if (rdy4) v4        <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_st   <= st_next;
      s1_ch   <= ch_next;
      s1_hz   <= hz_next;
      s1_kbps <= kbps_next;
      s1_pad  <= header_word[9];
      s1_sel  <= sel_next;
      s1_s125 <= s125_next;
    end
    if (rdy2) begin
      s2_st   <= s1_st;
      s2_ch   <= s1_ch;
      s2_hz   <= s1_hz;
      s2_kbps <= s1_kbps;
      s2_pad  <= s1_pad;
      s2_sel  <= s1_sel;
      s2_n    <= prod2[26:0];
    end
    if (rdy3) begin
      s3_st   <= s2_st;
      s3_ch   <= s2_ch;
      s3_hz   <= s2_hz;
      s3_kbps <= s2_kbps;
      s3_pad  <= s2_pad;
      s3_sel  <= s2_sel;
      s3_n    <= s2_n;
      s3_q    <= prod3[RECIP_SH+11:RECIP_SH];
    end
    if (rdy4) begin
      s4_st   <= s3_st;
      s4_ch   <= s3_ch;
      s4_hz   <= s3_hz;
      s4_kbps <= s3_kbps;
      s4_pad  <= s3_pad;
      s4_sel  <= s3_sel;
      s4_n    <= s3_n;
      s4_q    <= s3_q;
      s4_qb   <= prod4;
    end
    if (rdy5) begin
      status         <= s4_st;
      channels       <= s4_ch;
      sample_rate_hz <= s4_hz;
      bit_rate_kbps  <= s4_kbps;
      padding_bit    <= s4_pad;
      frame_bytes    <= (s4_st == ST_OK) ? bytes5 : '0;
    end
  end

  // An empty output register means every stage can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty pipeline");

  // Reciprocal quotient is never more than one below the true quotient
  a_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    (v4 && s4_st == ST_OK) |-> (rem5 < 28'({base5, 1'b0})))
    else $error("reciprocal quotient off by more than one");

  // Error words carry no rate, bitrate or length
  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |->
      (frame_bytes == '0 && sample_rate_hz == '0 && bit_rate_kbps == '0))
    else $error("error word with nonzero decoded values");

  // Free format length is just the padding slot
  a_free_format: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK && bit_rate_kbps == '0) |->
      (frame_bytes == 12'(padding_bit)))
    else $error("free format length wrong");

  // A good header always has a sample rate
  a_ok_has_rate: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> (sample_rate_hz != '0))
    else $error("good header with zero sample rate");

endmodule
